[hdl/ads2_pkg.sv]
`default_nettype none
package ads2_pkg;

  // Default geometry and sample precision
  localparam int MAX_WIDTH_DEF   = 1024;
  localparam int MAX_CHANS_DEF   = 16;
  localparam int SAMPLE_BITS_DEF = 24;

  // Fixed limits from the register widths
  localparam int MAX_HEIGHT    = 1024;
  localparam int ROW_BITS      = 10;
  localparam int IMG_BITS      = 16;
  localparam int CH_REG_BITS   = 5;
  localparam int DIM_REG_BITS  = 11;
  localparam int CFG_DATA_BITS = 16;

  // Register reset values
  localparam logic [CH_REG_BITS-1:0]  CHANNELS_RST    = CH_REG_BITS'(1);
  localparam logic [DIM_REG_BITS-1:0] IN_WIDTH_RST    = DIM_REG_BITS'(2);
  localparam logic [DIM_REG_BITS-1:0] IN_HEIGHT_RST   = DIM_REG_BITS'(2);
  localparam logic [IMG_BITS-1:0]     IMAGE_COUNT_RST = IMG_BITS'(1);

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_CHANNELS    = 2'd0,
    CFG_IN_WIDTH    = 2'd1,
    CFG_IN_HEIGHT   = 2'd2,
    CFG_IMAGE_COUNT = 2'd3
  } cfg_index_t;

endpackage
`default_nettype wire

[hdl/area_downsample_2x2_unit.sv]
`default_nettype none
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_stall  in_sample
// out      output     out_valid / out_stall out_average, out_last_of_image, out_last_of_batch
// cfg      input      cfg_we               cfg_index, cfg_wdata
//
// One sample is taken per cycle while in_stall is low; a result leaves through the add
// stage and the output register after the fourth sample of its 2x2 block. Each sample makes
// a single read-modify-write pass through the pair-sum line store: read on acceptance, add
// and write back as the add stage advances, last write forwarded for back-to-back entry use.
// Synchronous active-low reset clears the position counters, pipeline valids and
// registers; the line store is not cleared and needs no clearing pass.
// A stalled output holds its request and stalls the input only once the add stage
// must hand a result to the still-full output register.
module area_downsample_2x2_unit #(
  parameter int MAX_WIDTH   = ads2_pkg::MAX_WIDTH_DEF,
  parameter int MAX_CHANS   = ads2_pkg::MAX_CHANS_DEF,
  parameter int SAMPLE_BITS = ads2_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0]      in_sample,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic signed [SAMPLE_BITS-1:0]           out_average,
  output logic                                    out_last_of_image,
  output logic                                    out_last_of_batch,
  input  wire logic                               cfg_we,
  input  wire ads2_pkg::cfg_index_t               cfg_index,
  input  wire logic [ads2_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);
  import ads2_pkg::*;

  localparam int SUM_BITS   = SAMPLE_BITS + 2;
  localparam int LINE_DEPTH = (MAX_WIDTH / 2) * MAX_CHANS;
  localparam int IDX_BITS   = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int CH_BITS    = (MAX_CHANS > 1) ? $clog2(MAX_CHANS) : 1;
  localparam int COL_BITS   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  // Configuration registers
  logic [CH_REG_BITS-1:0]  channels_r;
  logic [DIM_REG_BITS-1:0] in_width_r;
  logic [DIM_REG_BITS-1:0] in_height_r;
  logic [IMG_BITS-1:0]     image_count_r;

  // Stream position
  logic [CH_BITS-1:0]  ch_pos_r, ch_pos_nxt;
  logic [COL_BITS-1:0] col_pos_r, col_pos_nxt;
  logic [ROW_BITS-1:0] row_pos_r, row_pos_nxt;
  logic [IMG_BITS-1:0] img_pos_r, img_pos_nxt;

  // Effective last positions
  logic [CH_BITS-1:0]  ch_last;
  logic [COL_BITS-1:0] col_last;
  logic [ROW_BITS-1:0] row_last;
  logic [IMG_BITS-1:0] img_last;
  logic                last_ch, last_col, last_row, last_img;
  logic                odd_col, odd_row;
  logic [IDX_BITS-1:0] rd_idx;

  // Add stage
  logic                          s1_valid_r;
  logic signed [SAMPLE_BITS-1:0] s1_sample_r;
  logic [IDX_BITS-1:0]           s1_idx_r;
  logic                          s1_first_r;
  logic                          s1_emit_r;
  logic                          s1_end_img_r;
  logic                          s1_end_batch_r;
  logic                          s1_adv;
  logic signed [SUM_BITS-1:0]    base;
  logic signed [SUM_BITS-1:0]    acc;

  // Line store and forwarding of the last write
  logic [SUM_BITS-1:0]           line_mem [LINE_DEPTH];
  logic [SUM_BITS-1:0]           rd_data_r;
  logic                          lw_valid_r;
  logic [IDX_BITS-1:0]           lw_idx_r;
  logic [SUM_BITS-1:0]           lw_data_r;

  // Output register
  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_average_r;
  logic                          out_last_of_image_r;
  logic                          out_last_of_batch_r;

  logic in_accept;
  logic mem_we;

  // Hold configuration written by the register port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channels_r    <= CHANNELS_RST;
      in_width_r    <= IN_WIDTH_RST;
      in_height_r   <= IN_HEIGHT_RST;
      image_count_r <= IMAGE_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CHANNELS:    channels_r    <= cfg_wdata[CH_REG_BITS-1:0];
        CFG_IN_WIDTH:    in_width_r    <= cfg_wdata[DIM_REG_BITS-1:0];
        CFG_IN_HEIGHT:   in_height_r   <= cfg_wdata[DIM_REG_BITS-1:0];
        CFG_IMAGE_COUNT: image_count_r <= cfg_wdata[IMG_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Round width and height down to even, saturate geometry into its legal range and derive last positions
  always_comb begin
    int ch_i;
    int w_i;
    int h_i;
    ch_i = int'(channels_r);
    if (ch_i < 1) ch_i = 1;
    if (ch_i > MAX_CHANS) ch_i = MAX_CHANS;
    w_i = int'({in_width_r[DIM_REG_BITS-1:1], 1'b0});
    if (w_i < 2) w_i = 2;
    if (w_i > MAX_WIDTH) w_i = MAX_WIDTH;
    h_i = int'({in_height_r[DIM_REG_BITS-1:1], 1'b0});
    if (h_i < 2) h_i = 2;
    if (h_i > MAX_HEIGHT) h_i = MAX_HEIGHT;
    ch_last  = CH_BITS'(ch_i - 1);
    col_last = COL_BITS'(w_i - 1);
    row_last = ROW_BITS'(h_i - 1);
    img_last = (image_count_r == '0) ? '0 : image_count_r - IMG_BITS'(1);
  end

  assign last_ch  = (ch_pos_r >= ch_last);
  assign last_col = (col_pos_r >= col_last);
  assign last_row = (row_pos_r >= row_last);
  assign last_img = (img_pos_r >= img_last);
  assign odd_col  = col_pos_r[0];
  assign odd_row  = row_pos_r[0];
  assign rd_idx   = IDX_BITS'(int'(col_pos_r >> 1) * MAX_CHANS + int'(ch_pos_r));

  // Advance the stream position
  always_comb begin
    ch_pos_nxt  = ch_pos_r;
    col_pos_nxt = col_pos_r;
    row_pos_nxt = row_pos_r;
    img_pos_nxt = img_pos_r;
    if (!last_ch) begin
      ch_pos_nxt = ch_pos_r + CH_BITS'(1);
    end else begin
      ch_pos_nxt = '0;
      if (!last_col) begin
        col_pos_nxt = col_pos_r + COL_BITS'(1);
      end else begin
        col_pos_nxt = '0;
        if (!last_row) begin
          row_pos_nxt = row_pos_r + ROW_BITS'(1);
        end else begin
          row_pos_nxt = '0;
          img_pos_nxt = last_img ? '0 : img_pos_r + IMG_BITS'(1);
        end
      end
    end
  end

  // Handshakes
  assign s1_adv    = s1_valid_r && (!s1_emit_r || !out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_accept = in_valid && !in_stall;
  assign mem_we    = s1_adv && !s1_emit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_pos_r  <= '0;
      col_pos_r <= '0;
      row_pos_r <= '0;
      img_pos_r <= '0;
    end else if (in_accept) begin
      ch_pos_r  <= ch_pos_nxt;
      col_pos_r <= col_pos_nxt;
      row_pos_r <= row_pos_nxt;
      img_pos_r <= img_pos_nxt;
    end
  end

  // Capture the request into the add stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_sample_r    <= in_sample;
      s1_idx_r       <= rd_idx;
      s1_first_r     <= !odd_row && !odd_col;
      s1_emit_r      <= odd_row && odd_col;
      s1_end_img_r   <= last_ch && last_col && last_row;
      s1_end_batch_r <= last_ch && last_col && last_row && last_img;
    end
  end

  // Read the line store on acceptance, write back the partial sum
  always_ff @(posedge clk) begin
    if (in_accept) begin
      rd_data_r <= line_mem[rd_idx];
    end
    if (mem_we) begin
      line_mem[s1_idx_r] <= acc;
    end
  end

  // Keep the last write for a read that overlaps it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_valid_r <= 1'b0;
    end else if (mem_we) begin
      lw_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      lw_idx_r  <= s1_idx_r;
      lw_data_r <= acc;
    end
  end

  // Add the sample to the stored partial sum, or start a new sum on a block's first sample
  always_comb begin
    base = (lw_valid_r && (lw_idx_r == s1_idx_r)) ? signed'(lw_data_r) : signed'(rd_data_r);
    if (s1_first_r) begin
      acc = {{2{s1_sample_r[SAMPLE_BITS-1]}}, s1_sample_r};
    end else begin
      acc = base + {{2{s1_sample_r[SAMPLE_BITS-1]}}, s1_sample_r};
    end
  end

  // Load the output register, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_emit_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_emit_r) begin
      out_average_r       <= SAMPLE_BITS'(acc >>> 2);
      out_last_of_image_r <= s1_end_img_r;
      out_last_of_batch_r <= s1_end_batch_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_average       = out_average_r;
  assign out_last_of_image = out_last_of_image_r;
  assign out_last_of_batch = out_last_of_batch_r;

  // Checks
  a_batch_ends_image: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_last_of_batch_r || out_last_of_image_r))
    else $error("end of batch without end of image");

  a_emit_not_first: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_emit_r) |-> !s1_first_r)
    else $error("block result on the first sample of a block");

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_idx_r) && $stable(rd_data_r)))
    else $error("add stage lost its request while held");

  a_forward_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |=> (lw_valid_r && (lw_idx_r == $past(s1_idx_r))))
    else $error("forwarding register missed a write");

endmodule
`default_nettype wire
